// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL. Empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge, skipped while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/core/hse_pkg.sv =====
`timescale 1ns / 1ps

package hse_pkg;

    // Field widths
    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;

    // One slot: valid bit over the stored word
    localparam int ENTRY_W = VALUE_W + 1;

    // Operation codes (code 3 behaves as a query)
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0] t_count;

endpackage

// ===== rtl/core/hash_set_engine.sv =====
`timescale 1ns / 1ps
// Hashed set of 32-bit values, one bucket row per memory word.
// Sequence: with BUCKETS a power of two the row read issues from S_IDLE on the low value bits;
// otherwise S_HASH, S_FOLD and S_RD first form the reciprocal-multiply bucket modulo.
// One word at a time: ready is high only in S_IDLE, and the row read is followed by the row write-back
// in S_UPD on the single-port-pair bucket memory; S_UPD waits while the result channel is stalled.
// Reset: synchronous; a clearing pass writes zero to every bucket row before ready rises.
`include "assert_macros.svh"

module hash_set_engine #(
    parameter int BUCKETS          = 256,
    parameter int SLOTS_PER_BUCKET = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [hse_pkg::OP_W-1:0]      i_operation,
    input  logic signed [hse_pkg::VALUE_W-1:0] i_value,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_present,
    output logic [hse_pkg::COUNT_W-1:0]   o_member_count,
    output logic                          o_bucket_full
);

    localparam int BW      = $clog2(BUCKETS);
    localparam int SW      = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int ROW_W   = SLOTS_PER_BUCKET * hse_pkg::ENTRY_W;
    localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

    // Bucket modulo by reciprocal: quotient = (value * RECIP_M) >> SHR, exact over 32 bits
    localparam int SHR     = hse_pkg::VALUE_W + BW;
    localparam int RW      = hse_pkg::VALUE_W + 1;
    localparam int PW      = hse_pkg::VALUE_W + RW;
    localparam int QW      = PW - SHR;
    localparam logic [RW-1:0] RECIP_M =
        RW'(((64'd1 << SHR) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
    localparam hse_pkg::t_value BUCK_V = hse_pkg::t_value'(BUCKETS);

    localparam logic [BW-1:0]   LAST_ROW = BW'(BUCKETS - 1);

    // State codes
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_HASH = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_FOLD = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [BW-1:0]           r_clr_idx;
    logic [hse_pkg::OP_W-1:0] r_op;
    hse_pkg::t_value         r_value;
    logic [BW-1:0]           r_bucket, n_bucket;
    logic [QW-1:0]           r_quot;
    hse_pkg::t_count         r_count, n_count;
    logic                    r_out_valid;
    logic                    r_present;
    logic                    r_full;

    // Bucket memory: one row of slots per bucket
    logic [ROW_W-1:0]        r_mem [BUCKETS];
    logic [ROW_W-1:0]        r_rd_row;

    logic                    mem_re, mem_we;
    logic [BW-1:0]           mem_raddr, mem_waddr;
    logic [ROW_W-1:0]        mem_wdata;

    logic                    in_acc;
    logic                    ld_out;
    logic                    clr_last;
    logic [PW-1:0]           quot_prod;
    hse_pkg::t_value         rem_full;

    logic                    hit_any, free_any;
    logic [SW-1:0]           hit_idx, free_idx;
    logic                    do_ins, do_rem, ins_full;
    logic [ROW_W-1:0]        new_row;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign clr_last   = (r_clr_idx == LAST_ROW);
    assign ld_out     = (r_state == S_UPD) && (!r_out_valid || i_out_ready);

    // Reciprocal multiply, then fold the quotient back out of the value
    assign quot_prod = PW'(r_value) * PW'(RECIP_M);
    assign rem_full  = r_value - hse_pkg::t_value'(r_quot) * BUCK_V;

    // Slot compare across the row just read
    always_comb begin
        logic [hse_pkg::ENTRY_W-1:0] ent;
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
            ent = r_rd_row[s*hse_pkg::ENTRY_W +: hse_pkg::ENTRY_W];
            if (ent[hse_pkg::VALUE_W]) begin
                if (ent[hse_pkg::VALUE_W-1:0] == r_value) begin
                    hit_any = 1'b1;
                    hit_idx = SW'(s);
                end
            end else begin
                free_any = 1'b1;
                free_idx = SW'(s);
            end
        end
    end

    // Row modification
    always_comb begin
        do_ins   = (r_op == hse_pkg::OP_INSERT) && !hit_any && free_any;
        ins_full = (r_op == hse_pkg::OP_INSERT) && !hit_any && !free_any;
        do_rem   = (r_op == hse_pkg::OP_REMOVE) && hit_any;
        new_row  = r_rd_row;
        if (do_ins) begin
            new_row[free_idx*hse_pkg::ENTRY_W +: hse_pkg::ENTRY_W] = {1'b1, r_value};
        end
        if (do_rem) begin
            new_row[hit_idx*hse_pkg::ENTRY_W +: hse_pkg::ENTRY_W] = '0;
        end
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + 1'b1;
        end else if (do_rem) begin
            n_count = r_count - 1'b1;
        end
    end

    // Sequencer and memory port control
    always_comb begin
        n_state   = r_state;
        n_bucket  = r_bucket;
        mem_re    = 1'b0;
        mem_raddr = r_bucket;
        mem_we    = 1'b0;
        mem_waddr = r_bucket;
        mem_wdata = new_row;
        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = '0;
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (IS_POW2) begin
                        n_bucket  = i_value[BW-1:0];
                        mem_re    = 1'b1;
                        mem_raddr = i_value[BW-1:0];
                        n_state   = S_UPD;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                n_state = S_FOLD;
            end
            S_FOLD: begin
                n_bucket = rem_full[BW-1:0];
                n_state  = S_RD;
            end
            S_RD: begin
                mem_re  = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                if (ld_out) begin
                    mem_we  = do_ins || do_rem;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_idx   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (ld_out) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_operation;
            r_value <= i_value;
        end
        r_bucket <= n_bucket;
        if (r_state == S_HASH) begin
            r_quot <= quot_prod[PW-1:SHR];
        end
        if (ld_out) begin
            r_present <= hit_any;
            r_full    <= ins_full;
        end
    end

    // Bucket memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_row <= r_mem[mem_raddr];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_present      = r_present;
    assign o_member_count = r_count;
    assign o_bucket_full  = r_full;

    // Read and write of the row never share a cycle
    `ASSERT_ALWAYS(a_no_rw_overlap, i_clk, !(mem_re && mem_we))
    // A dropped insert can only be for an absent value
    `ASSERT_CLK(a_full_not_present, i_clk, i_rst_n, (o_out_valid && o_bucket_full) |-> !o_present)
    // Count only moves on an actual insert or remove
    `ASSERT_CLK(a_count_stable, i_clk, i_rst_n, (ld_out && !do_ins && !do_rem) |=> $stable(r_count))
    // No words are taken before the clearing pass ends
    `ASSERT_CLK(a_clr_blocks, i_clk, i_rst_n, (r_state == S_CLR && !clr_last) |=> !o_in_ready)

endmodule
